FILE: rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// shared types and codes for the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

    typedef enum logic [1:0] {
        STAT_TWO    = 2'd0,
        STAT_DOUBLE = 2'd1,
        STAT_NONE   = 2'd2,
        STAT_A_ZERO = 2'd3
    } status_t;

    localparam int STATUS_W = 2;

endpackage

FILE: rtl/qrs_disc.sv
// ----------------------------------------------------------------------------
// qrs_disc
// two-stage discriminant: products, then b*b - 4*a*c
// ----------------------------------------------------------------------------
module qrs_disc #(
    parameter int COEF_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [COEF_BITS-1:0] a,
    input  logic signed [COEF_BITS-1:0] b,
    input  logic signed [COEF_BITS-1:0] c,
    output logic                       out_valid,
    output logic signed [COEF_BITS-1:0] a_o,
    output logic signed [COEF_BITS-1:0] b_o,
    output logic signed [2*COEF_BITS+1:0] d_o
);

    localparam int PROD_W = 2 * COEF_BITS;
    localparam int DISC_W = 2 * COEF_BITS + 2;

    logic                        v1_reg;
    logic signed [PROD_W-1:0]    bb_reg;
    logic signed [PROD_W-1:0]    ac_reg;
    logic signed [COEF_BITS-1:0] a1_reg;
    logic signed [COEF_BITS-1:0] b1_reg;

    logic                        v2_reg;
    logic signed [DISC_W-1:0]    d2_reg;
    logic signed [COEF_BITS-1:0] a2_reg;
    logic signed [COEF_BITS-1:0] b2_reg;

    logic signed [DISC_W-1:0]    d_next;

    always_comb
    begin
        d_next = DISC_W'(bb_reg) - (DISC_W'(ac_reg) <<< 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg <= b * b;
            ac_reg <= a * c;
            a1_reg <= a;
            b1_reg <= b;
            d2_reg <= d_next;
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign a_o       = a2_reg;
    assign b_o       = b2_reg;
    assign d_o       = d2_reg;

endmodule

FILE: rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined bit-pair square root of d * 2^(2*FRAC_BITS), one root bit a stage
// ----------------------------------------------------------------------------
module qrs_sqrt #(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16,
    parameter int SB_W      = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [2*COEF_BITS+1:0]       d,
    input  logic [SB_W-1:0]              sb,
    output logic                         out_valid,
    output logic [2*COEF_BITS+1:0]       d_o,
    output logic [SB_W-1:0]              sb_o,
    output logic [COEF_BITS+FRAC_BITS:0] root
);

    localparam int DISC_W = 2 * COEF_BITS + 2;
    localparam int RT_W   = COEF_BITS + FRAC_BITS + 1;
    localparam int REM_W  = RT_W + 3;

    logic              v_reg    [RT_W];
    logic [REM_W-1:0]  rem_reg  [RT_W];
    logic [RT_W-1:0]   root_reg [RT_W];
    logic [DISC_W-1:0] d_reg    [RT_W];
    logic [SB_W-1:0]   sb_reg   [RT_W];

    genvar k;
    generate
        for (k = 0; k < RT_W; k++)
        begin : g_stage
            localparam int POS = 2 * (RT_W - 1 - k) - 2 * FRAC_BITS;

            logic              v_in;
            logic [REM_W-1:0]  rem_in;
            logic [RT_W-1:0]   root_in;
            logic [DISC_W-1:0] d_in;
            logic [SB_W-1:0]   sb_in;
            logic [1:0]        pair;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic              ge;

            if (k == 0)
            begin : g_first
                assign v_in    = in_valid;
                assign rem_in  = '0;
                assign root_in = '0;
                assign d_in    = d;
                assign sb_in   = sb;
            end
            else
            begin : g_rest
                assign v_in    = v_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign d_in    = d_reg[k-1];
                assign sb_in   = sb_reg[k-1];
            end

            if (POS >= 0)
            begin : g_pair
                assign pair = d_in[POS +: 2];
            end
            else
            begin : g_zero
                assign pair = 2'b00;
            end

            always_comb
            begin
                rem_sh = {rem_in[REM_W-3:0], pair};
                trial  = REM_W'({root_in, 2'b01});
                ge     = (rem_sh >= trial);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                    root_reg[k] <= {root_in[RT_W-2:0], ge};
                    d_reg[k]    <= d_in;
                    sb_reg[k]   <= sb_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[RT_W-1];
    assign d_o       = d_reg[RT_W-1];
    assign sb_o      = sb_reg[RT_W-1];
    assign root      = root_reg[RT_W-1];

endmodule

FILE: rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// two-lane pipelined restoring divider with a shared divisor, one quotient
// bit a stage
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 17,
    parameter int SB_W  = 38
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num_p,
    input  logic [NUM_W-1:0] num_m,
    input  logic [DEN_W-1:0] den,
    input  logic [SB_W-1:0]  sb,
    output logic             out_valid,
    output logic [NUM_W-1:0] quo_p,
    output logic [NUM_W-1:0] quo_m,
    output logic [SB_W-1:0]  sb_o
);

    localparam int RW = DEN_W + 1;

    logic             v_reg   [NUM_W];
    logic [NUM_W-1:0] num_reg [2][NUM_W];
    logic [RW-1:0]    rem_reg [2][NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [SB_W-1:0]  sb_reg  [NUM_W];

    genvar k, l;
    generate
        for (k = 0; k < NUM_W; k++)
        begin : g_stage
            logic             v_in;
            logic [DEN_W-1:0] den_in;
            logic [SB_W-1:0]  sb_in;

            if (k == 0)
            begin : g_first
                assign v_in   = in_valid;
                assign den_in = den;
                assign sb_in  = sb;
            end
            else
            begin : g_rest
                assign v_in   = v_reg[k-1];
                assign den_in = den_reg[k-1];
                assign sb_in  = sb_reg[k-1];
            end

            for (l = 0; l < 2; l++)
            begin : g_lane
                logic [NUM_W-1:0] num_in;
                logic [RW-1:0]    rem_in;
                logic [RW-1:0]    rem_sh;
                logic             ge;

                if (k == 0)
                begin : g_first
                    assign num_in = (l == 0) ? num_p : num_m;
                    assign rem_in = '0;
                end
                else
                begin : g_rest
                    assign num_in = num_reg[l][k-1];
                    assign rem_in = rem_reg[l][k-1];
                end

                always_comb
                begin
                    rem_sh = {rem_in[RW-2:0], num_in[NUM_W-1]};
                    ge     = (rem_sh >= RW'(den_in));
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[l][k] <= ge ? (rem_sh - RW'(den_in)) : rem_sh;
                        num_reg[l][k] <= {num_in[NUM_W-2:0], ge};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k] <= den_in;
                    sb_reg[k]  <= sb_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NUM_W-1];
    assign quo_p     = num_reg[0][NUM_W-1];
    assign quo_m     = num_reg[1][NUM_W-1];
    assign sb_o      = sb_reg[NUM_W-1];

endmodule

FILE: rtl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x^2 + b*x + c in signed fixed point
// ----------------------------------------------------------------------------
// Fully pipelined: one coefficient set is taken every cycle while the pipeline
// is not held, and each coefficient set gives one result. The stages are two
// for the discriminant, COEF_BITS+FRAC_BITS+1 for the square root (one root
// bit a stage), one to form the numerators, COEF_BITS+FRAC_BITS+2 in the
// divider (one per quotient bit), and the output register. The whole pipeline
// holds while a finished result waits on root_ready. root_status is 0 for
// two roots, 1 for a double root, 2 for no real roots and 3 when a is zero;
// in the last two cases both roots read 0. Roots carry FRAC_BITS fraction
// bits and are truncated toward zero.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   coef_valid,
    output logic                                   coef_ready,
    input  logic signed [COEF_BITS-1:0]            coef_a,
    input  logic signed [COEF_BITS-1:0]            coef_b,
    input  logic signed [COEF_BITS-1:0]            coef_c,
    output logic                                   root_valid,
    input  logic                                   root_ready,
    output logic [1:0]                             root_status,
    output logic signed [COEF_BITS+FRAC_BITS+2:0]  root_plus,
    output logic signed [COEF_BITS+FRAC_BITS+2:0]  root_minus,
    output logic signed [2*COEF_BITS+1:0]          discriminant
);

    localparam int DISC_W = 2 * COEF_BITS + 2;
    localparam int RT_W   = COEF_BITS + FRAC_BITS + 1;
    localparam int ROOT_W = COEF_BITS + FRAC_BITS + 3;
    localparam int NUM_W  = ROOT_W - 1;
    localparam int DEN_W  = COEF_BITS + 1;
    localparam int SQ_SB  = 2 * COEF_BITS;
    localparam int DV_SB  = qrs_pkg::STATUS_W + 2 + DISC_W;

    logic en;

    // discriminant
    logic                        dc_valid;
    logic signed [COEF_BITS-1:0] dc_a;
    logic signed [COEF_BITS-1:0] dc_b;
    logic signed [DISC_W-1:0]    dc_d;

    // square root
    logic                        sq_valid;
    logic [DISC_W-1:0]           sq_d;
    logic [SQ_SB-1:0]            sq_sb;
    logic [RT_W-1:0]             sq_root;
    logic signed [COEF_BITS-1:0] sq_a;
    logic signed [COEF_BITS-1:0] sq_b;

    // numerator stage
    logic                        nm_valid_reg;
    logic [NUM_W-1:0]            nm_p_reg;
    logic [NUM_W-1:0]            nm_m_reg;
    logic [DEN_W-1:0]            nm_den_reg;
    logic [DV_SB-1:0]            nm_sb_reg;

    logic signed [ROOT_W-1:0]    nb;
    logic signed [ROOT_W-1:0]    num_p;
    logic signed [ROOT_W-1:0]    num_m;
    logic signed [DEN_W-1:0]     a_ext;
    logic [DEN_W-1:0]            den_next;
    logic                        neg_p;
    logic                        neg_m;
    qrs_pkg::status_t            status_next;
    logic [DV_SB-1:0]            nm_sb_next;

    // divider
    logic                        dv_valid;
    logic [NUM_W-1:0]            dv_qp;
    logic [NUM_W-1:0]            dv_qm;
    logic [DV_SB-1:0]            dv_sb;
    qrs_pkg::status_t            dv_status;
    logic                        dv_neg_p;
    logic                        dv_neg_m;
    logic [DISC_W-1:0]           dv_d;
    logic signed [ROOT_W-1:0]    rp_next;
    logic signed [ROOT_W-1:0]    rm_next;

    // output register
    logic                        out_valid_reg;
    logic [1:0]                  status_reg;
    logic signed [ROOT_W-1:0]    rp_reg;
    logic signed [ROOT_W-1:0]    rm_reg;
    logic signed [DISC_W-1:0]    d_reg;

    // pipeline advances unless a finished result is held
    assign en         = !out_valid_reg || root_ready;
    assign coef_ready = en;

    qrs_disc #(
        .COEF_BITS (COEF_BITS)
    ) u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (coef_valid),
        .a         (coef_a),
        .b         (coef_b),
        .c         (coef_c),
        .out_valid (dc_valid),
        .a_o       (dc_a),
        .b_o       (dc_b),
        .d_o       (dc_d)
    );

    qrs_sqrt #(
        .COEF_BITS (COEF_BITS),
        .FRAC_BITS (FRAC_BITS),
        .SB_W      (SQ_SB)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dc_valid),
        .d         (dc_d),
        .sb        ({dc_a, dc_b}),
        .out_valid (sq_valid),
        .d_o       (sq_d),
        .sb_o      (sq_sb),
        .root      (sq_root)
    );

    assign sq_a = sq_sb[SQ_SB-1 -: COEF_BITS];
    assign sq_b = sq_sb[COEF_BITS-1:0];

    always_comb
    begin
        nb    = -(ROOT_W'(sq_b) <<< FRAC_BITS);
        num_p = nb + $signed(ROOT_W'(sq_root));
        num_m = nb - $signed(ROOT_W'(sq_root));
        a_ext = DEN_W'(sq_a);
        den_next = (a_ext[DEN_W-1] ? DEN_W'(-a_ext) : DEN_W'(a_ext)) << 1;
        neg_p = num_p[ROOT_W-1] ^ sq_a[COEF_BITS-1];
        neg_m = num_m[ROOT_W-1] ^ sq_a[COEF_BITS-1];

        if (sq_a == '0)
        begin
            status_next = qrs_pkg::STAT_A_ZERO;
        end
        else if (sq_d[DISC_W-1])
        begin
            status_next = qrs_pkg::STAT_NONE;
        end
        else if (sq_d == '0)
        begin
            status_next = qrs_pkg::STAT_DOUBLE;
        end
        else
        begin
            status_next = qrs_pkg::STAT_TWO;
        end

        nm_sb_next = {status_next, neg_p, neg_m, sq_d};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            nm_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_p_reg   <= num_p[ROOT_W-1] ? NUM_W'(-num_p) : NUM_W'(num_p);
            nm_m_reg   <= num_m[ROOT_W-1] ? NUM_W'(-num_m) : NUM_W'(num_m);
            nm_den_reg <= den_next;
            nm_sb_reg  <= nm_sb_next;
        end
    end

    qrs_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .SB_W  (DV_SB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_valid_reg),
        .num_p     (nm_p_reg),
        .num_m     (nm_m_reg),
        .den       (nm_den_reg),
        .sb        (nm_sb_reg),
        .out_valid (dv_valid),
        .quo_p     (dv_qp),
        .quo_m     (dv_qm),
        .sb_o      (dv_sb)
    );

    always_comb
    begin
        dv_status = qrs_pkg::status_t'(dv_sb[DV_SB-1 -: qrs_pkg::STATUS_W]);
        dv_neg_p  = dv_sb[DISC_W+1];
        dv_neg_m  = dv_sb[DISC_W];
        dv_d      = dv_sb[DISC_W-1:0];

        if (dv_status inside {qrs_pkg::STAT_NONE, qrs_pkg::STAT_A_ZERO})
        begin
            rp_next = '0;
            rm_next = '0;
        end
        else
        begin
            rp_next = dv_neg_p ? -$signed(ROOT_W'(dv_qp)) : $signed(ROOT_W'(dv_qp));
            rm_next = dv_neg_m ? -$signed(ROOT_W'(dv_qm)) : $signed(ROOT_W'(dv_qm));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= dv_status;
            rp_reg     <= rp_next;
            rm_reg     <= rm_next;
            d_reg      <= $signed(dv_d);
        end
    end

    assign root_valid   = out_valid_reg;
    assign root_status  = status_reg;
    assign root_plus    = rp_reg;
    assign root_minus   = rm_reg;
    assign discriminant = d_reg;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks quadratic_root_solver against an in-bench model of the formula
// ----------------------------------------------------------------------------
// Coefficient sets go in through coef_valid/coef_ready. Each transfer queues the
// expected status, roots and discriminant. Every root transfer is compared with
// the oldest expected entry. Both sides stall in random bursts, the receiver
// holds off once for a long stretch, and the sender pauses twice until drained.
// ----------------------------------------------------------------------------
module tb;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int RW = CB + FB + 3;
    localparam int DW = 2 * CB + 2;
    localparam int LATENCY = 2 * CB + 2 * FB + 7;

    typedef struct packed {
        qrs_pkg::status_t     status;
        logic signed [RW-1:0] plus;
        logic signed [RW-1:0] minus;
        logic signed [DW-1:0] disc;
    } root_set_t;

    logic clk = 0;
    logic rst_n = 0;
    logic coef_valid = 0;
    logic coef_ready;
    logic signed [CB-1:0] coef_a = '0;
    logic signed [CB-1:0] coef_b = '0;
    logic signed [CB-1:0] coef_c = '0;
    logic root_valid;
    logic root_ready = 0;
    logic [1:0] root_status;
    logic signed [RW-1:0] root_plus;
    logic signed [RW-1:0] root_minus;
    logic signed [DW-1:0] discriminant;

    root_set_t expected_roots[$];
    int  errors = 0;
    bit  quiet = 0;     // no idling in the last part
    int  hold_off = 0;  // long receiver stall, in cycles

    quadratic_root_solver dut (.*);

    always #5 clk = ~clk;

    // floor(sqrt(d * 2^(2*FB)))
    function automatic longint unsigned scaled_root(longint unsigned d);
        longint unsigned r;
        longint unsigned rem;
        longint unsigned trial;
        int pos;
        r = 0;
        rem = 0;
        for (int i = DW / 2 + FB - 1; i >= 0; i--) begin
            pos = 2 * i - 2 * FB;
            rem = (rem << 2) | ((pos >= 0) ? ((d >> pos) & 3) : 0);
            trial = (r << 2) | 1;
            if (rem >= trial) begin
                rem -= trial;
                r = (r << 1) | 1;
            end
            else
                r = r << 1;
        end
        return r;
    endfunction

    function automatic root_set_t solve_quadratic(logic signed [CB-1:0] a,
                                                  logic signed [CB-1:0] b,
                                                  logic signed [CB-1:0] c);
        root_set_t res;
        longint d;
        longint s;
        longint nb;
        longint den;
        d = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
        res.plus = '0;
        res.minus = '0;
        res.disc = d[DW-1:0];
        if (a == 0)
            res.status = qrs_pkg::STAT_A_ZERO;
        else if (d < 0)
            res.status = qrs_pkg::STAT_NONE;
        else begin
            s = longint'(scaled_root(longint'(d)));
            nb = -longint'(b) * (longint'(1) << FB);
            den = 2 * longint'(a);
            res.status = (d == 0) ? qrs_pkg::STAT_DOUBLE : qrs_pkg::STAT_TWO;
            res.plus = RW'((nb + s) / den);
            res.minus = RW'((nb - s) / den);
        end
        return res;
    endfunction

    task automatic send_coefs(logic signed [CB-1:0] a, logic signed [CB-1:0] b,
                              logic signed [CB-1:0] c);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            coef_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        coef_valid <= 1;
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        @(posedge clk);
        while (!coef_ready) @(posedge clk);
        expected_roots.push_back(solve_quadratic(a, b, c));
        @(negedge clk);
    endtask

    task automatic drop_valid();
        coef_valid <= 0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (expected_roots.size() != 0) @(negedge clk);
    endtask

    // receiver side
    initial begin
        int burst;
        forever begin
            @(negedge clk);
            if (hold_off > 0) begin
                root_ready <= 0;
                hold_off--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 17);
                root_ready <= 0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                root_ready <= 1;
        end
    end

    // result checker
    always @(posedge clk) begin
        root_set_t exp;
        if (rst_n && root_valid && root_ready) begin
            if (expected_roots.size() == 0) begin
                $error("root transfer with nothing expected");
                errors++;
            end
            else begin
                exp = expected_roots.pop_front();
                if (root_status !== exp.status) begin
                    $error("root_status exp %0d got %0d", exp.status, root_status);
                    errors++;
                end
                if (root_plus !== exp.plus) begin
                    $error("root_plus exp %0d got %0d", exp.plus, root_plus);
                    errors++;
                end
                if (root_minus !== exp.minus) begin
                    $error("root_minus exp %0d got %0d", exp.minus, root_minus);
                    errors++;
                end
                if (discriminant !== exp.disc) begin
                    $error("discriminant exp %0d got %0d", exp.disc, discriminant);
                    errors++;
                end
            end
        end
    end

    task automatic test_extremes();
        logic signed [CB-1:0] edges[5] = '{16'sh8000, 16'sh7fff, 0, 1, -1};
        foreach (edges[i])
            send_coefs(edges[i], edges[(i + 1) % 5], edges[(i + 3) % 5]);
        send_coefs(16'sh7fff, 16'sh8000, 16'sh8000);  // largest discriminant
        send_coefs(16'sh8000, 16'sh8000, 16'sh8000);
        send_coefs(16'sh8000, 16'sh0000, 16'sh8000);  // most negative discriminant
        send_coefs(16'sh8000, 16'sh7fff, 16'sh7fff);
    endtask

    task automatic test_special_cases();
        send_coefs(1, -3, 2);     // two roots
        send_coefs(-2, 5, 3);     // two roots, negative a
        send_coefs(1, 2, 1);      // double root
        send_coefs(-3, 12, -12);  // double root, negative a
        send_coefs(1, 0, 1);      // no real roots
        send_coefs(0, 5, 7);      // a is zero
        send_coefs(0, 0, 0);
        send_coefs(3, 1, -1);     // irrational roots
        send_coefs(16'sh7fff, 1, 0);
    endtask

    task automatic test_random(int n);
        logic signed [CB-1:0] a;
        logic signed [CB-1:0] b;
        logic signed [CB-1:0] c;
        int k;
        for (int i = 0; i < n; i++) begin
            a = $urandom;
            b = $urandom;
            c = $urandom;
            case ($urandom_range(0, 5))
                0: a = $urandom_range(0, 8) - 4;
                1: begin
                    // perfect square: b^2 = 4ac, c kept within 16 bits
                    k = $urandom_range(0, 50) - 25;
                    a = $urandom_range(1, 50) * (($urandom_range(0, 1)) ? 1 : -1);
                    b = 2 * a * k;
                    c = a * k * k;
                end
                2: c = -(a * ($urandom_range(0, 1) ? 1 : -1)) >>> $urandom_range(0, 8);
                default: ;
            endcase
            send_coefs(a, b, c);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        for (int i = 0; i < 150; i++)
            send_coefs($urandom, $urandom, $urandom);
        wait_drained();
        repeat (LATENCY) @(negedge clk);
        test_random(50);
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_extremes();
        test_special_cases();
        test_random(600);
        test_backpressure();
        test_random(300);
        quiet = 1;
        test_random(130);
        drop_valid();
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: sim.f
rtl/qrs_pkg.sv
rtl/qrs_disc.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver.sv
tb/tb.sv
